[rtl/dnd_pkg.sv]
// Shared types and constants for the DNS name decompressor.
package dnd_pkg;

  // Position width covers every packet size in range plus a label's length.
  localparam int POS_W = 15;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Top two bits of a label length byte
  localparam logic [1:0] TAG_LABEL = 2'b00;
  localparam logic [1:0] TAG_EXT   = 2'b01;
  localparam logic [1:0] TAG_RSVD  = 2'b10;
  localparam logic [1:0] TAG_PTR   = 2'b11;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_RESERVED = 3'd2;
  localparam logic [2:0] ST_FORWARD  = 3'd3;
  localparam logic [2:0] ST_LONG     = 3'd4;

  typedef struct packed {
    logic [63:0] name_bytes;
    logic [3:0]  byte_count;
    logic        last;
    logic [2:0]  status;
    logic [9:0]  end_offset;
  } result_t;

endpackage

[rtl/dnd_store.sv]
// Packet byte store: one write port, one read port with registered data.
module dnd_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/dnd_walker.sv]
// Label walker: reads the store, follows pointers, packs name bytes into items.
module dnd_walker #(
  parameter int PACKET_BYTES     = 512,
  parameter int MAX_NAME_BYTES   = 256,
  parameter int BYTES_PER_RESULT = 8,
  parameter int AW               = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [7:0]        data_byte,
  input  logic [8:0]        offset,
  input  logic [9:0]        packet_length,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic [AW-1:0]     rd_addr,
  input  logic [7:0]        rd_data,
  output logic              res_valid,
  output dnd_pkg::result_t  res,
  input  logic              res_ready
);

  import dnd_pkg::*;

  localparam int NCW = $clog2(MAX_NAME_BYTES + 65);
  localparam logic [POS_W-1:0] PKT_LEN  = POS_W'(PACKET_BYTES);
  localparam logic [NCW-1:0]   NAME_MAX = NCW'(MAX_NAME_BYTES);
  localparam logic [3:0]       BPR_CNT  = 4'(BYTES_PER_RESULT);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LABEL = 6'b000010,
    S_PTR   = 6'b000100,
    S_COPY  = 6'b001000,
    S_DOT   = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] len, len_next;
  logic [POS_W-1:0] tag_pos, tag_pos_next;
  logic [POS_W-1:0] resume, resume_next;
  logic             ptr_taken, ptr_taken_next;
  logic [5:0]       ptr_hi, ptr_hi_next;
  logic [5:0]       cnt, cnt_next;
  logic [NCW-1:0]   name_len, name_len_next;
  logic [63:0]      pend_word, pend_word_next;
  logic [3:0]       pend_cnt, pend_cnt_next;
  logic [2:0]       status_r, status_next;
  logic [9:0]       end_r, end_next;

  logic [POS_W-1:0] rd_pos;
  logic [POS_W-1:0] off_ext, plen_ext, plen_clamp, pos_inc, target;
  logic             push, push_ok, full;
  logic [7:0]       push_data;
  logic [63:0]      word_merged;

  assign off_ext    = POS_W'(offset);
  assign plen_ext   = POS_W'(packet_length);
  assign plen_clamp = (plen_ext > PKT_LEN) ? PKT_LEN : plen_ext;
  assign pos_inc    = pos + POS_W'(1);
  assign target     = POS_W'({ptr_hi, rd_data});

  assign word_merged = pend_word | (64'(push_data) << {pend_cnt[2:0], 3'b000});
  assign full        = (pend_cnt + 4'd1) == BPR_CNT;
  assign push_ok     = !full || res_ready;

  assign rd_addr = rd_pos[AW-1:0];
  assign wr_addr = off_ext[AW-1:0];
  assign wr_data = data_byte;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    len_next       = len;
    tag_pos_next   = tag_pos;
    resume_next    = resume;
    ptr_taken_next = ptr_taken;
    ptr_hi_next    = ptr_hi;
    cnt_next       = cnt;
    name_len_next  = name_len;
    pend_word_next = pend_word;
    pend_cnt_next  = pend_cnt;
    status_next    = status_r;
    end_next       = end_r;
    rd_pos         = pos;
    wr_en          = 1'b0;
    push           = 1'b0;
    push_data      = DOT_CHAR;
    res_valid      = 1'b0;
    res            = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_DECODE) begin
            len_next       = plen_clamp;
            pos_next       = off_ext;
            rd_pos         = off_ext;
            resume_next    = '0;
            ptr_taken_next = 1'b0;
            name_len_next  = '0;
            pend_word_next = '0;
            pend_cnt_next  = '0;
            end_next       = '0;
            if (off_ext >= plen_clamp) begin
              status_next = ST_TRUNC;
              state_next  = S_FINAL;
            end else begin
              state_next = S_LABEL;
            end
          end else begin
            wr_en = (off_ext < PKT_LEN);
          end
        end
      end

      S_LABEL: begin
        if (pos >= len) begin
          status_next = ST_TRUNC;
          state_next  = S_FINAL;
        end else if (rd_data == 8'h00) begin
          status_next = ST_OK;
          end_next    = ptr_taken ? resume[9:0] : pos_inc[9:0];
          state_next  = S_FINAL;
        end else if (rd_data[7:6] == TAG_EXT || rd_data[7:6] == TAG_RSVD) begin
          status_next = ST_RESERVED;
          state_next  = S_FINAL;
        end else if (rd_data[7:6] == TAG_PTR) begin
          if (pos_inc >= len) begin
            status_next = ST_TRUNC;
            state_next  = S_FINAL;
          end else begin
            tag_pos_next = pos;
            ptr_hi_next  = rd_data[5:0];
            pos_next     = pos_inc;
            rd_pos       = pos_inc;
            state_next   = S_PTR;
          end
        end else begin
          if (pos_inc + POS_W'(rd_data[5:0]) > len) begin
            status_next = ST_TRUNC;
            state_next  = S_FINAL;
          end else if (name_len + NCW'(rd_data[5:0]) + NCW'(1) > NAME_MAX) begin
            status_next = ST_LONG;
            state_next  = S_FINAL;
          end else begin
            cnt_next      = rd_data[5:0];
            name_len_next = name_len + NCW'(rd_data[5:0]) + NCW'(1);
            pos_next      = pos_inc;
            rd_pos        = pos_inc;
            state_next    = S_COPY;
          end
        end
      end

      S_PTR: begin
        // Only strictly backward targets may be followed
        if (target >= tag_pos) begin
          status_next = ST_FORWARD;
          state_next  = S_FINAL;
        end else begin
          if (!ptr_taken) begin
            ptr_taken_next = 1'b1;
            resume_next    = pos_inc;
          end
          pos_next   = target;
          rd_pos     = target;
          state_next = S_LABEL;
        end
      end

      S_COPY: begin
        push      = 1'b1;
        push_data = rd_data;
        // On a stall rd_pos stays at pos, so the byte is read again
        if (push_ok) begin
          pos_next = pos_inc;
          rd_pos   = pos_inc;
          cnt_next = cnt - 6'd1;
          if (cnt == 6'd1) begin
            state_next = S_DOT;
          end
        end
      end

      S_DOT: begin
        push = 1'b1;
        if (push_ok) begin
          state_next = S_LABEL;
        end
      end

      S_FINAL: begin
        res_valid = 1'b1;
        res.last  = 1'b1;
        res.status = status_r;
        if (status_r == ST_OK) begin
          res.name_bytes = pend_word;
          res.byte_count = pend_cnt;
          res.end_offset = end_r;
        end
        if (res_ready) begin
          pend_word_next = '0;
          pend_cnt_next  = '0;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (push) begin
      if (full) begin
        res_valid      = 1'b1;
        res.name_bytes = word_merged;
        res.byte_count = BPR_CNT;
        if (push_ok) begin
          pend_word_next = '0;
          pend_cnt_next  = '0;
        end
      end else begin
        pend_word_next = word_merged;
        pend_cnt_next  = pend_cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr_taken <= 1'b0;
      name_len  <= '0;
      pend_cnt  <= '0;
      pend_word <= '0;
    end else begin
      state     <= state_next;
      ptr_taken <= ptr_taken_next;
      name_len  <= name_len_next;
      pend_cnt  <= pend_cnt_next;
      pend_word <= pend_word_next;
    end
    pos       <= pos_next;
    len       <= len_next;
    tag_pos   <= tag_pos_next;
    resume    <= resume_next;
    ptr_hi    <= ptr_hi_next;
    cnt       <= cnt_next;
    status_r  <= status_next;
    end_r     <= end_next;
  end

  a_mid_item_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> res.byte_count == BPR_CNT)
    else $error("intermediate item not full");

  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last && res.status != ST_OK |->
      res.byte_count == 4'd0 && res.end_offset == 10'd0 && res.name_bytes == 64'd0)
    else $error("error item carries name data");

  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    name_len <= NAME_MAX)
    else $error("name length beyond limit");

  a_decode_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_DECODE |=> state != S_IDLE)
    else $error("decode accepted but walker idle");

  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_STORE |=> state == S_IDLE && !res_valid)
    else $error("store item left walker busy");

endmodule

[rtl/dnd_out.sv]
// Output register: holds one result item while the receiver stalls.
module dnd_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  dnd_pkg::result_t res,
  output logic             res_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output dnd_pkg::result_t out_res
);

  import dnd_pkg::*;

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

[rtl/dns_name_decompressor_unit.sv]
// Top level of the DNS name decompressor.
//
// Input channel (in_valid/in_stall): op 0 stores data_byte at offset in the
// packet store, one item per cycle outside a decode, no result. Op 1 decodes
// the name that starts at offset within the first packet_length bytes.
// Output channel (out_valid/out_stall): name characters with '.' after each
// label, BYTES_PER_RESULT to an item, first character in the lowest byte.
// The item with last set carries status; on OK also the offset after the name.
// A decode holds in_stall high until its last item is in the output register.
// It steps through a start, each label length byte, each name byte, each '.',
// each pointer (tag byte, then target byte) and the final item, reading the
// bytes through the single read port of the packet store.
// When the receiver stalls, the output register holds its item and the walker
// waits at its next item; nothing is dropped.
// Reset clears the walker and the output valid; the packet store is not
// cleared and holds what was written before.
module dns_name_decompressor_unit #(
  parameter int PACKET_BYTES     = 512,
  parameter int MAX_NAME_BYTES   = 256,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  input  logic [8:0]  offset,
  input  logic [9:0]  packet_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] name_bytes,
  output logic [3:0]  byte_count,
  output logic        last,
  output logic [2:0]  status,
  output logic [9:0]  end_offset
);

  import dnd_pkg::*;

  localparam int AW = $clog2(PACKET_BYTES);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_res;

  dnd_store #(
    .DEPTH (PACKET_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dnd_walker #(
    .PACKET_BYTES     (PACKET_BYTES),
    .MAX_NAME_BYTES   (MAX_NAME_BYTES),
    .BYTES_PER_RESULT (BYTES_PER_RESULT),
    .AW               (AW)
  ) u_walker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .data_byte     (data_byte),
    .offset        (offset),
    .packet_length (packet_length),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  dnd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign name_bytes = out_res.name_bytes;
  assign byte_count = out_res.byte_count;
  assign last       = out_res.last;
  assign status     = out_res.status;
  assign end_offset = out_res.end_offset;

endmodule

[dv/dns_name_decompressor_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the DNS name decompressor: packet store writes and name decodes.
module dns_name_decompressor_unit_tb;
  import dnd_pkg::*;

  localparam int STORE_DEPTH  = 512;
  localparam int NAME_LIMIT   = 256;
  localparam int WORD_BYTES   = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 310;

  class name_scoreboard;
    bit [7:0]    pkt_mirror [STORE_DEPTH];
    bit          written [STORE_DEPTH];
    result_t     expected_names [$];
    result_t     walk_out [$];
    logic [63:0] pend_word;
    int          pend_count;
    int          failures;

    function void push_char(logic [7:0] c);
      pend_word[8*pend_count +: 8] = c;
      pend_count++;
      if (pend_count == WORD_BYTES) begin
        walk_out.push_back(result_t'{pend_word, 4'(WORD_BYTES), 1'b0, ST_OK, 10'd0});
        pend_word  = '0;
        pend_count = 0;
      end
    endfunction

    // Walk the name at start into walk_out; return 1 if an unwritten entry would be read.
    function bit decode_name(int start, int plen);
      int         len;
      int         pos;
      int         tag_pos;
      int         resume;
      int         target;
      int         name_len;
      bit         ptr_taken;
      bit         touched;
      bit         done;
      logic [7:0] b;
      logic [2:0] st;
      walk_out.delete();
      pend_word  = '0;
      pend_count = 0;
      len        = (plen > STORE_DEPTH) ? STORE_DEPTH : plen;
      pos        = start;
      resume     = 0;
      name_len   = 0;
      ptr_taken  = 1'b0;
      touched    = 1'b0;
      done       = 1'b0;
      st         = ST_OK;
      while (!done) begin
        tag_pos = pos;
        if (pos >= len) begin
          st   = ST_TRUNC;
          done = 1'b1;
        end else begin
          touched |= !written[pos];
          b = pkt_mirror[pos];
          pos++;
          if (b == 8'h00) begin
            done = 1'b1;
          end else if (b[7:6] == TAG_EXT || b[7:6] == TAG_RSVD) begin
            st   = ST_RESERVED;
            done = 1'b1;
          end else if (b[7:6] == TAG_PTR) begin
            if (pos >= len) begin
              st   = ST_TRUNC;
              done = 1'b1;
            end else begin
              touched |= !written[pos];
              target = {b[5:0], pkt_mirror[pos]};
              pos++;
              if (target >= tag_pos) begin
                st   = ST_FORWARD;
                done = 1'b1;
              end else begin
                // end offset comes from the first pointer only
                if (!ptr_taken) begin
                  ptr_taken = 1'b1;
                  resume    = pos;
                end
                pos = target;
              end
            end
          end else if (pos + b > len) begin
            st   = ST_TRUNC;
            done = 1'b1;
          end else if (name_len + b + 1 > NAME_LIMIT) begin
            st   = ST_LONG;
            done = 1'b1;
          end else begin
            for (int i = 0; i < b; i++) begin
              touched |= !written[pos + i];
              push_char(pkt_mirror[pos + i]);
            end
            push_char(DOT_CHAR);
            name_len += b + 1;
            pos      += b;
          end
        end
      end
      if (st == ST_OK)
        walk_out.push_back(result_t'{pend_word, 4'(pend_count), 1'b1, ST_OK,
                                     10'(ptr_taken ? resume : pos)});
      else
        walk_out.push_back(result_t'{64'd0, 4'd0, 1'b1, st, 10'd0});
      return touched;
    endfunction

    function void note_item(logic op_i, logic [7:0] d, int off, int plen);
      if (op_i == OP_STORE) begin
        pkt_mirror[off] = d;
        written[off]    = 1'b1;
      end else begin
        void'(decode_name(off, plen));
        foreach (walk_out[i]) expected_names.push_back(walk_out[i]);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_names.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected item: bytes=%h count=%0d last=%0b status=%0d end=%0d",
                   $realtime, got.name_bytes, got.byte_count, got.last, got.status,
                   got.end_offset);
        return;
      end
      want = expected_names.pop_front();
      if (got.name_bytes !== want.name_bytes || got.byte_count !== want.byte_count ||
          got.last !== want.last || got.status !== want.status ||
          got.end_offset !== want.end_offset) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: mismatch: expected bytes=%h count=%0d last=%0b status=%0d end=%0d",
                   $realtime, want.name_bytes, want.byte_count, want.last, want.status,
                   want.end_offset);
          $display("%0t:           actual bytes=%h count=%0d last=%0b status=%0d end=%0d",
                   $realtime, got.name_bytes, got.byte_count, got.last, got.status,
                   got.end_offset);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_STORE;
  logic [7:0]  data_byte = 8'd0;
  logic [8:0]  offset = 9'd0;
  logic [9:0]  packet_length = 10'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] name_bytes;
  logic [3:0]  byte_count;
  logic        last;
  logic [2:0]  status;
  logic [9:0]  end_offset;

  name_scoreboard sb_names = new();
  int             items_sent;
  int             decodes_sent;
  bit             quiet;
  bit             hold_req;

  dns_name_decompressor_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .data_byte     (data_byte),
    .offset        (offset),
    .packet_length (packet_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .name_bytes    (name_bytes),
    .byte_count    (byte_count),
    .last          (last),
    .status        (status),
    .end_offset    (end_offset)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_item(logic op_i, logic [7:0] d, int off, int plen);
    if (!quiet) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    op            <= op_i;
    data_byte     <= d;
    offset        <= 9'(off);
    packet_length <= 10'(plen);
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb_names.note_item(op_i, d, off, plen);
    items_sent++;
    if (op_i == OP_DECODE) decodes_sent++;
  endtask

  task automatic send_store(int addr, logic [7:0] d);
    send_item(OP_STORE, d, addr, $urandom_range(1023));
  endtask

  // Fall back to a packet length equal to start when the walk would touch unwritten entries.
  task automatic send_decode(int start, int plen);
    if (sb_names.decode_name(start, plen)) plen = start;
    send_item(OP_DECODE, 8'($urandom_range(255)), start, plen);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb_names.expected_names.size() != 0) @(posedge clk);
  endtask

  task automatic directed_items();
    // label 'a' followed by a pointer back to itself: runs into the name limit
    send_store(0, 8'h01);
    send_store(1, "a");
    send_store(2, {TAG_PTR, 6'd0});
    send_store(3, 8'h00);
    send_store(4, 8'h01);
    send_store(5, "x");
    send_store(6, {TAG_PTR, 6'd0});
    send_store(7, 8'h03);
    send_store(8, {TAG_EXT, 6'h05});
    send_store(9, {TAG_RSVD, 6'h3f});
    send_store(10, 8'hff);
    send_store(11, 8'hff);
    send_store(507, 8'h01);
    send_store(508, "Z");
    send_store(509, 8'h00);
    send_store(510, 8'hc1);
    send_store(511, 8'hfb);
    send_decode(0, 4);
    send_decode(3, 4);
    send_decode(4, 8);
    send_decode(4, 5);
    send_decode(6, 7);
    send_decode(511, 0);
    send_decode(8, 9);
    send_decode(9, 10);
    send_decode(10, 12);
    send_decode(510, 1023);
  endtask

  task automatic packet_round();
    logic [7:0] pkt_bytes [$];
    int         label_at [$];
    int         name_at [$];
    int         base;
    int         pos;
    int         nn;
    int         nl;
    int         len;
    int         target;
    int         kind;
    int         start;
    int         plen;
    base = ($urandom_range(3) == 0) ? $urandom_range(280) : 0;
    pos  = base;
    nn   = $urandom_range(1, 3);
    for (int n = 0; n < nn && pos + 8 <= STORE_DEPTH; n++) begin
      name_at.push_back(pos);
      nl = $urandom_range(0, 4);
      for (int j = 0; j < nl; j++) begin
        len = ($urandom_range(15) == 0) ? 63 : $urandom_range(1, 10);
        if (pos + len + 8 > STORE_DEPTH) break;
        label_at.push_back(pos);
        pkt_bytes.push_back(8'(len));
        repeat (len) pkt_bytes.push_back(8'($urandom_range(255)));
        pos += len + 1;
      end
      kind = $urandom_range(9);
      if (kind < 4 || label_at.size() == 0) begin
        pkt_bytes.push_back(8'h00);
        pos++;
      end else if (kind < 8) begin
        // back pointer, possibly into this same name, which loops until the limit
        target = label_at[$urandom_range(label_at.size() - 1)];
        pkt_bytes.push_back({TAG_PTR, 6'(target >> 8)});
        pkt_bytes.push_back(8'(target));
        pos += 2;
      end else if (kind == 8) begin
        target = pos + $urandom_range(16383 - pos);
        pkt_bytes.push_back({TAG_PTR, 6'(target >> 8)});
        pkt_bytes.push_back(8'(target));
        pos += 2;
      end else begin
        pkt_bytes.push_back({($urandom_range(1) ? TAG_EXT : TAG_RSVD), 6'($urandom_range(63))});
        pos++;
      end
    end
    // corrupt a byte now and then
    if ($urandom_range(4) == 0)
      pkt_bytes[$urandom_range(pkt_bytes.size() - 1)] = 8'($urandom_range(255));
    foreach (pkt_bytes[i]) send_store(base + i, pkt_bytes[i]);
    repeat ($urandom_range(3, 6)) begin
      kind = $urandom_range(9);
      if (kind < 6)
        start = name_at[$urandom_range(name_at.size() - 1)];
      else if (kind < 8 && label_at.size() != 0)
        start = label_at[$urandom_range(label_at.size() - 1)];
      else
        start = base + $urandom_range(pkt_bytes.size() - 1);
      kind = $urandom_range(9);
      if (kind < 6)
        plen = pos;
      else if (kind < 8)
        plen = $urandom_range(start, pos);
      else
        plen = $urandom_range(1023);
      send_decode(start, plen);
    end
  endtask

  initial begin : result_side
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
        sb_names.check_result(result_t'{name_bytes, byte_count, last, status, end_offset});
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall <= (hold_left > 0) || (!quiet && $urandom_range(99) < 13);
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin : stimulus
    int rounds;
    int random_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    directed_items();
    wait_drained();
    random_start = items_sent;
    rounds       = 0;
    while (items_sent - random_start < RANDOM_ITEMS || decodes_sent < 40) begin
      // hold the receiver off while decodes keep coming
      if (rounds == 1) hold_req = 1'b1;
      if (rounds == 3) wait_drained();
      quiet = (rounds == 4 || rounds == 5);
      packet_round();
      rounds++;
    end
    quiet = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb_names.failures == 0 && sb_names.expected_names.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
